[hw/rtl/fqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types, sizes and helpers for the circular queue with search.
// ----------------------------------------------------------------------------
package fqs_pkg;

    // ring size and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths of the item payloads
    localparam int MODE_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // operation codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ   = 3'd0,
        MODE_DEQ   = 3'd1,
        MODE_PEEK  = 3'd2,
        MODE_FIND  = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    // next slot around the ring
    function automatic addr_t ring_next(input addr_t idx);
        addr_t nxt;
        if (idx == addr_t'(DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + addr_t'(1);
        end
        return nxt;
    endfunction

endpackage

[hw/rtl/fqs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqs_in_if
// Command channel: one operation per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqs_in_if;

    logic                                valid;
    logic                                ready;
    logic [fqs_pkg::MODE_W-1:0]          mode;
    logic signed [fqs_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

[hw/rtl/fqs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqs_out_if
// Result channel: one result item per operation, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqs_out_if;

    logic                                valid;
    logic                                ready;
    logic [fqs_pkg::STAT_W-1:0]          status;
    logic signed [fqs_pkg::DATA_W-1:0]   data_out;
    logic [fqs_pkg::POS_W-1:0]           position;
    logic [fqs_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output status, output data_out, output position,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data_out, input position,
                    input occupancy, output ready);

endinterface

[hw/rtl/fqs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqs_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqs_ram (
    input  logic                        clk,
    input  logic                        we,
    input  fqs_pkg::addr_t              waddr,
    input  logic [fqs_pkg::DATA_W-1:0]  wdata,
    input  logic                        re,
    input  fqs_pkg::addr_t              raddr,
    output logic [fqs_pkg::DATA_W-1:0]  rdata
);

    logic [fqs_pkg::DATA_W-1:0] mem [fqs_pkg::DEPTH];
    logic [fqs_pkg::DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fifo_queue_with_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Ring-buffer queue with enqueue, dequeue, peek, find and clear operations.
// ----------------------------------------------------------------------------
// Sequence: a command is accepted only in idle; dequeue and peek read the head
//   entry in read, a find compares k entries in scan with one read each. No
//   new command is taken until the last result is loaded; a full output
//   register holds the command channel until the result is taken.
// Reset: head, tail, count and output valid clear at once; the entry memory
//   is not cleared, an entry is only read after it has been written.
module fifo_queue_with_search (
    input  logic      clk,
    input  logic      rst_n,
    fqs_in_if.sink    cmd,
    fqs_out_if.source rsp
);

    // control and pointer state
    fqs_pkg::state_t  state_reg,  state_next;
    fqs_pkg::addr_t   head_reg,   head_next;
    fqs_pkg::addr_t   tail_reg,   tail_next;
    fqs_pkg::cnt_t    count_reg,  count_next;
    logic             out_valid_reg;

    // latched command and scan progress
    logic [fqs_pkg::DATA_W-1:0] value_reg;
    fqs_pkg::addr_t   scan_idx_reg, scan_idx_next;
    fqs_pkg::addr_t   scan_k_reg,   scan_k_next;

    // result waiting for the output register
    fqs_pkg::status_t           res_status_reg, res_status_next;
    logic [fqs_pkg::DATA_W-1:0] res_data_reg,   res_data_next;
    fqs_pkg::addr_t             res_pos_reg,    res_pos_next;

    // output register
    fqs_pkg::status_t           out_status_reg;
    logic [fqs_pkg::DATA_W-1:0] out_data_reg;
    fqs_pkg::addr_t             out_pos_reg;
    fqs_pkg::cnt_t              out_occ_reg;

    // memory port signals
    logic                       mem_we;
    logic                       mem_re;
    fqs_pkg::addr_t             mem_raddr;
    logic [fqs_pkg::DATA_W-1:0] mem_rdata;

    // finishing result of the current cycle
    logic                       fin;
    fqs_pkg::status_t           fin_status;
    logic [fqs_pkg::DATA_W-1:0] fin_data;
    fqs_pkg::addr_t             fin_pos;

    logic accept;
    logic out_free;
    logic out_load;
    logic is_full;
    logic is_empty;
    logic scan_hit;
    logic scan_last;

    // handshake and status terms
    assign cmd.ready = (state_reg == fqs_pkg::ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = fin && out_free;
    assign is_full   = (count_reg == fqs_pkg::cnt_t'(fqs_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);
    assign scan_hit  = (mem_rdata == value_reg);
    assign scan_last = ((fqs_pkg::cnt_t'(scan_k_reg) + fqs_pkg::cnt_t'(1)) == count_reg);

    // entry storage; writes only happen in idle, reads in idle and scan
    fqs_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tail_reg),
        .wdata (cmd.value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (fqs_pkg::mode_t'(cmd.mode))
                        fqs_pkg::MODE_DEQ,
                        fqs_pkg::MODE_PEEK:
                        begin
                            state_next = is_empty ? fqs_pkg::ST_DONE : fqs_pkg::ST_READ;
                        end
                        fqs_pkg::MODE_FIND:
                        begin
                            state_next = is_empty ? fqs_pkg::ST_DONE : fqs_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = fqs_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            fqs_pkg::ST_READ:
            begin
                state_next = out_free ? fqs_pkg::ST_IDLE : fqs_pkg::ST_DONE;
            end
            fqs_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = out_free ? fqs_pkg::ST_IDLE : fqs_pkg::ST_DONE;
                end
            end
            fqs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fqs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control per state
    always_comb
    begin
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = head_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        scan_k_next     = scan_k_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        fin             = 1'b0;
        fin_status      = fqs_pkg::STAT_OK;
        fin_data        = '0;
        fin_pos         = '0;

        unique case (state_reg)
            fqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = fqs_pkg::STAT_OK;
                    res_data_next   = '0;
                    res_pos_next    = '0;
                    unique case (fqs_pkg::mode_t'(cmd.mode))
                        fqs_pkg::MODE_ENQ:
                        begin
                            if (is_full)
                            begin
                                res_status_next = fqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                tail_next  = fqs_pkg::ring_next(tail_reg);
                                count_next = count_reg + fqs_pkg::cnt_t'(1);
                            end
                        end
                        fqs_pkg::MODE_DEQ:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = fqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                head_next  = fqs_pkg::ring_next(head_reg);
                                count_next = count_reg - fqs_pkg::cnt_t'(1);
                            end
                        end
                        fqs_pkg::MODE_PEEK:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = fqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        fqs_pkg::MODE_FIND:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = fqs_pkg::STAT_NOTFOUND;
                            end
                            else
                            begin
                                mem_re        = 1'b1;
                                scan_idx_next = fqs_pkg::ring_next(head_reg);
                                scan_k_next   = '0;
                            end
                        end
                        fqs_pkg::MODE_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = fqs_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            fqs_pkg::ST_READ:
            begin
                fin      = 1'b1;
                fin_data = mem_rdata;
            end
            fqs_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    fin      = 1'b1;
                    fin_data = value_reg;
                    fin_pos  = scan_k_reg;
                end
                else if (scan_last)
                begin
                    fin        = 1'b1;
                    fin_status = fqs_pkg::STAT_NOTFOUND;
                end
                else
                begin
                    // fetch the next entry around the ring
                    mem_re        = 1'b1;
                    mem_raddr     = scan_idx_reg;
                    scan_idx_next = fqs_pkg::ring_next(scan_idx_reg);
                    scan_k_next   = scan_k_reg + fqs_pkg::addr_t'(1);
                end
            end
            fqs_pkg::ST_DONE:
            begin
                fin        = 1'b1;
                fin_status = res_status_reg;
                fin_data   = res_data_reg;
                fin_pos    = res_pos_reg;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        // hold a finished result while the output register is occupied
        if (fin && !out_free)
        begin
            res_status_next = fin_status;
            res_data_next   = fin_data;
            res_pos_next    = fin_pos;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqs_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= cmd.value;
        end
        scan_idx_reg   <= scan_idx_next;
        scan_k_reg     <= scan_k_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        if (out_load)
        begin
            out_status_reg <= fin_status;
            out_data_reg   <= fin_data;
            out_pos_reg    <= fin_pos;
            out_occ_reg    <= count_reg;
        end
    end

    // result channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.position  = fqs_pkg::POS_W'(out_pos_reg);
    assign rsp.occupancy = fqs_pkg::OCC_W'(out_occ_reg);

endmodule
